// ===== design/bm3_pkg.sv =====
// Shared constants and types for the 3x3 edge-clipped box mean.
// No dependencies; used by the top level, the divider and the port checker.
package bm3_pkg;

    // fixed field widths
    localparam int CFG_W = 11;   // side length register
    localparam int POS_W = 10;   // row / column fields of a result
    localparam int CNT_W = 4;    // neighbor count, at most 9

    localparam int SIDE_RESET = 8;

    // request type codes
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    // which window rows / columns lie inside the image
    typedef struct packed {
        logic top;
        logic bot;
        logic left;
        logic right;
    } edge_mask_t;

endpackage

// ===== design/bm3_div.sv =====
// Bit-serial restoring divider: unsigned dividend by a small neighbor count.
// One quotient bit per cycle. Depends on bm3_pkg for the count width.
module bm3_div #(
    parameter int DW = 19
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [DW-1:0]               dividend,
    input  logic [bm3_pkg::CNT_W-1:0]   divisor,
    output logic                        busy,
    output logic [DW-1:0]               quotient
);

    localparam int CNT_W  = bm3_pkg::CNT_W;
    localparam int STEP_W = $clog2(DW + 1);

    logic [DW-1:0]     quo_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [STEP_W-1:0] step_reg;

    logic [CNT_W:0]    trial;
    logic              fits;
    logic [CNT_W:0]    trial_sub;

    assign trial     = {rem_reg, quo_reg[DW-1]};
    assign fits      = trial >= {1'b0, div_reg};
    assign trial_sub = trial - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_W'(DW);
        end
        else if (step_reg != '0)
        begin
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (step_reg != '0)
        begin
            // remainder stays below the divisor, so it fits CNT_W bits
            rem_reg <= fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign busy     = step_reg != '0;
    assign quotient = quo_reg;

endmodule

// ===== design/box_mean_3x3_edge_clipped.sv =====
// Top level of the 3x3 edge-clipped box mean over a square raster image.
// Depends on bm3_pkg and bm3_div.
//
// Pixels of an N x N image (N from the side_length register, 0 read as 1,
// values above MAX_SIDE read as MAX_SIDE) enter in raster order; each result
// is the mean of the pixel's in-image 3x3 neighbors, truncated toward zero,
// with its row, column and an end-of-frame mark. Results trail the input by
// N+1 requests; after the last pixel, N+1 drain requests flush the rest.
// Drain requests arriving while pixels are still expected are dropped. The
// two previous image rows sit in one line memory, read and written back once
// per request that is not dropped. A request that yields no result holds off
// the input through the read-modify-write state; one that yields a result
// also through the row-sum, total, load and divide states, the last while the
// one-bit-per-cycle divider runs or a stalled result holds the output register.
// Writing side_length restarts the frame; line memory contents are kept.
module box_mean_3x3_edge_clipped #(
    parameter int MAX_SIDE   = 1024,
    parameter int PIXEL_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          side_length_we,
    input  logic [bm3_pkg::CFG_W-1:0]     side_length_wdata,

    input  logic                          pix_valid,
    output logic                          pix_stall,
    input  logic                          req_type,
    input  logic signed [PIXEL_BITS-1:0]  pixel_value,

    output logic                          res_valid,
    input  logic                          res_stall,
    output logic signed [PIXEL_BITS-1:0]  mean_value,
    output logic [bm3_pkg::POS_W-1:0]     out_row,
    output logic [bm3_pkg::POS_W-1:0]     out_col,
    output logic                          frame_last
);

    localparam int P        = PIXEL_BITS;
    localparam int SIDE_W   = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
    localparam int CW       = SIDE_W + 1;
    localparam int CFG_W    = bm3_pkg::CFG_W;
    localparam int CMP_W    = (CW > CFG_W + 1) ? CW : CFG_W + 1;
    localparam int POS_W    = bm3_pkg::POS_W;
    localparam int CNT_W    = bm3_pkg::CNT_W;
    localparam int RSUM_W   = P + 2;
    localparam int SUM_W    = P + 4;
    localparam int DIV_W    = P + 3;
    localparam int TAPS     = 9;
    localparam int SIDE_RST = (MAX_SIDE < bm3_pkg::SIDE_RESET) ? MAX_SIDE
                                                               : bm3_pkg::SIDE_RESET;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RMW  = 3'd1;
    localparam logic [2:0] ST_ROWS = 3'd2;
    localparam logic [2:0] ST_TOT  = 3'd3;
    localparam logic [2:0] ST_LOAD = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;

    logic [2:0]              state_reg, state_next;
    logic [SIDE_W-1:0]       side_reg;
    logic [ADDR_W-1:0]       in_col_reg;
    logic [CW-1:0]           in_row_reg;
    logic [CW-1:0]           warm_reg;
    logic [ADDR_W-1:0]       pos_col_reg;
    logic [ADDR_W-1:0]       pos_row_reg;

    // line memory: upper row in the high half, lower row in the low half
    logic [2*P-1:0]          line_mem [MAX_SIDE];
    logic [2*P-1:0]          rd_data_reg;
    logic signed [P-1:0]     v_reg;
    logic signed [P-1:0]     win_reg [TAPS];

    bm3_pkg::edge_mask_t     mask_reg;
    logic [ADDR_W-1:0]       item_row_reg;
    logic [ADDR_W-1:0]       item_col_reg;
    logic                    item_last_reg;
    logic signed [RSUM_W-1:0] rsum_reg [3];
    logic signed [SUM_W-1:0] sum_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    neg_reg;

    logic                    res_valid_reg;
    logic signed [P-1:0]     mean_reg;
    logic [POS_W-1:0]        row_out_reg;
    logic [POS_W-1:0]        col_out_reg;
    logic                    last_out_reg;

    logic [CW-1:0]           n_ext;
    logic                    draining;
    logic                    accept;
    logic                    drop;
    logic                    mem_re;
    logic                    mem_we;
    logic [CW-1:0]           in_col_inc;
    logic [CW-1:0]           pos_col_inc;
    logic [CW-1:0]           pos_row_inc;
    logic                    warming;
    bm3_pkg::edge_mask_t     mask_now;
    logic                    last_now;
    logic                    out_free;
    logic [CMP_W-1:0]        wdata_ext;
    logic [SIDE_W-1:0]       side_next;
    logic signed [P-1:0]     upper_rd;
    logic signed [P-1:0]     lower_rd;
    logic signed [RSUM_W-1:0] row_sum [3];
    logic [1:0]              rows_in;
    logic [1:0]              cols_in;
    logic signed [SUM_W-1:0] sum_abs;
    logic                    div_start;
    logic                    div_busy;
    logic [DIV_W-1:0]        div_quo;
    logic [P-1:0]            quo_p;
    logic [P-1:0]            mean_next;

    assign n_ext       = CW'(side_reg);
    assign draining    = in_row_reg >= n_ext;
    assign pix_stall   = state_reg != ST_IDLE;
    assign accept      = pix_valid && !pix_stall;
    assign drop        = (req_type == bm3_pkg::REQ_DRAIN) && !draining;
    assign mem_re      = accept && !drop;
    assign mem_we      = state_reg == ST_RMW;
    assign in_col_inc  = CW'(in_col_reg) + CW'(1);
    assign pos_col_inc = CW'(pos_col_reg) + CW'(1);
    assign pos_row_inc = CW'(pos_row_reg) + CW'(1);
    assign warming     = warm_reg <= n_ext;
    assign out_free    = !res_valid_reg || !res_stall;

    assign mask_now.top   = pos_row_reg != '0;
    assign mask_now.bot   = pos_row_inc < n_ext;
    assign mask_now.left  = pos_col_reg != '0;
    assign mask_now.right = pos_col_inc < n_ext;
    assign last_now       = !mask_now.bot && !mask_now.right;

    // clamp the written side into 1..MAX_SIDE
    assign wdata_ext = CMP_W'(side_length_wdata);
    always_comb
    begin
        if (wdata_ext == '0)
        begin
            side_next = SIDE_W'(1);
        end
        else if (wdata_ext > CMP_W'(MAX_SIDE))
        begin
            side_next = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            side_next = wdata_ext[SIDE_W-1:0];
        end
    end

    assign upper_rd = rd_data_reg[2*P-1:P];
    assign lower_rd = rd_data_reg[P-1:0];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            row_sum[r] = (mask_reg.left  ? RSUM_W'(win_reg[r*3])   : '0)
                       + RSUM_W'(win_reg[r*3+1])
                       + (mask_reg.right ? RSUM_W'(win_reg[r*3+2]) : '0);
        end
    end

    assign rows_in = 2'd1 + 2'(mask_reg.top) + 2'(mask_reg.bot);
    assign cols_in = 2'd1 + 2'(mask_reg.left) + 2'(mask_reg.right);
    assign sum_abs = sum_reg[SUM_W-1] ? -sum_reg : sum_reg;

    assign quo_p     = div_quo[P-1:0];
    assign mean_next = neg_reg ? (~quo_p + P'(1)) : quo_p;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (mem_re)
                begin
                    state_next = ST_RMW;
                end
            end
            ST_RMW:
            begin
                state_next = warming ? ST_IDLE : ST_ROWS;
            end
            ST_ROWS:
            begin
                state_next = ST_TOT;
            end
            ST_TOT:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy && out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign div_start = state_reg == ST_LOAD;

    bm3_div #(
        .DW(DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_abs[DIV_W-1:0]),
        .divisor  (cnt_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            side_reg      <= SIDE_W'(SIDE_RST);
            in_col_reg    <= '0;
            in_row_reg    <= '0;
            warm_reg      <= '0;
            pos_col_reg   <= '0;
            pos_row_reg   <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < TAPS; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (res_valid_reg && !res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (state_reg == ST_DIV && !div_busy && out_free)
            begin
                res_valid_reg <= 1'b1;
            end

            if (state_reg == ST_RMW)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]   <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                end
                win_reg[2] <= upper_rd;
                win_reg[5] <= lower_rd;
                win_reg[8] <= v_reg;
            end

            if (side_length_we)
            begin
                side_reg    <= side_next;
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                warm_reg    <= '0;
                pos_col_reg <= '0;
                pos_row_reg <= '0;
            end
            else if (state_reg == ST_RMW)
            begin
                if (warming)
                begin
                    warm_reg <= warm_reg + CW'(1);
                    if (in_col_inc >= n_ext)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + CW'(1);
                    end
                    else
                    begin
                        in_col_reg <= in_col_inc[ADDR_W-1:0];
                    end
                end
                else if (last_now)
                begin
                    // frame done: everything back to the origin
                    in_col_reg  <= '0;
                    in_row_reg  <= '0;
                    warm_reg    <= '0;
                    pos_col_reg <= '0;
                    pos_row_reg <= '0;
                end
                else
                begin
                    if (in_col_inc >= n_ext)
                    begin
                        in_col_reg <= '0;
                        in_row_reg <= in_row_reg + CW'(1);
                    end
                    else
                    begin
                        in_col_reg <= in_col_inc[ADDR_W-1:0];
                    end
                    if (pos_col_inc >= n_ext)
                    begin
                        pos_col_reg <= '0;
                        pos_row_reg <= pos_row_inc[ADDR_W-1:0];
                    end
                    else
                    begin
                        pos_col_reg <= pos_col_inc[ADDR_W-1:0];
                    end
                end
            end
        end
    end

    // line memory, one read and one write-back per request that is not dropped
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            line_mem[in_col_reg] <= {lower_rd, v_reg};
        end
        if (mem_re)
        begin
            rd_data_reg <= line_mem[in_col_reg];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            v_reg <= draining ? '0 : pixel_value;
        end
        if (state_reg == ST_RMW)
        begin
            mask_reg      <= mask_now;
            item_row_reg  <= pos_row_reg;
            item_col_reg  <= pos_col_reg;
            item_last_reg <= last_now;
        end
        if (state_reg == ST_ROWS)
        begin
            rsum_reg[0] <= mask_reg.top ? row_sum[0] : '0;
            rsum_reg[1] <= row_sum[1];
            rsum_reg[2] <= mask_reg.bot ? row_sum[2] : '0;
        end
        if (state_reg == ST_TOT)
        begin
            sum_reg <= SUM_W'(rsum_reg[0]) + SUM_W'(rsum_reg[1]) + SUM_W'(rsum_reg[2]);
            cnt_reg <= CNT_W'(rows_in) * CNT_W'(cols_in);
        end
        if (state_reg == ST_LOAD)
        begin
            neg_reg <= sum_reg[SUM_W-1];
        end
        if (state_reg == ST_DIV && !div_busy && out_free)
        begin
            mean_reg     <= mean_next;
            row_out_reg  <= POS_W'(item_row_reg);
            col_out_reg  <= POS_W'(item_col_reg);
            last_out_reg <= item_last_reg;
        end
    end

    assign res_valid  = res_valid_reg;
    assign mean_value = mean_reg;
    assign out_row    = row_out_reg;
    assign out_col    = col_out_reg;
    assign frame_last = last_out_reg;

endmodule

// ===== design/bm3_chk.sv =====
// Port-level checker for the box mean top level, bound in below.
// Depends on bm3_pkg for field widths and request codes.
module bm3_chk #(
    parameter int PIXEL_BITS = 16
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          side_length_we,
    input logic [bm3_pkg::CFG_W-1:0]     side_length_wdata,
    input logic                          pix_valid,
    input logic                          pix_stall,
    input logic                          req_type,
    input logic signed [PIXEL_BITS-1:0]  pixel_value,
    input logic                          res_valid,
    input logic                          res_stall,
    input logic signed [PIXEL_BITS-1:0]  mean_value,
    input logic [bm3_pkg::POS_W-1:0]     out_row,
    input logic [bm3_pkg::POS_W-1:0]     out_col,
    input logic                          frame_last
);

    // a stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(mean_value)
            && $stable(out_row) && $stable(out_col) && $stable(frame_last))
        else $error("stalled result changed");

    // square image: the final pixel sits on the diagonal
    a_last_diag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && frame_last |-> out_row == out_col)
        else $error("frame_last off the diagonal");

    // an accepted pixel request is always processed, so input stalls next
    a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall && req_type == bm3_pkg::REQ_PIXEL |=> pix_stall)
        else $error("pixel request not processed");

    // a new result is only produced while the input is held off
    a_res_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(pix_stall))
        else $error("result appeared without work in flight");

endmodule

bind box_mean_3x3_edge_clipped bm3_chk #(
    .PIXEL_BITS(PIXEL_BITS)
) u_bm3_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .side_length_we    (side_length_we),
    .side_length_wdata (side_length_wdata),
    .pix_valid         (pix_valid),
    .pix_stall         (pix_stall),
    .req_type          (req_type),
    .pixel_value       (pixel_value),
    .res_valid         (res_valid),
    .res_stall         (res_stall),
    .mean_value        (mean_value),
    .out_row           (out_row),
    .out_col           (out_col),
    .frame_last        (frame_last)
);
